/* hw/rtl/gdrm_pkg.sv */
package gdrm_pkg;

    // Field widths
    localparam int ETA_W   = 16;
    localparam int PHI_W   = 15;
    localparam int PT_W    = 20;
    localparam int REQ_W   = 2;
    localparam int MIDX_W  = 7;
    localparam int SEQ_W   = 6;
    localparam int CUT_W   = 32;
    localparam int ENTRY_W = ETA_W + PHI_W + PT_W;

    // Default table depth
    localparam int MAX_ENTRIES_DEF = 64;

    // Reset value of the squared cut: 0.2 squared in (1/4096)^2 units
    localparam logic [CUT_W-1:0] CUT_RESET = 32'd671089;

    // Phi wrap limits, units of 1/4096 rad
    localparam logic signed [PHI_W:0] PI_FIX     = 16'sd12868;
    localparam logic signed [PHI_W:0] TWO_PI_FIX = 16'sd25736;

    // Index reported when nothing qualifies
    localparam logic [MIDX_W-1:0] NO_MATCH = 7'h7F;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_MATCH = 2'd2
    } t_req;

endpackage

/* hw/rtl/gdrm_ram.sv */
module gdrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/greedy_delta_r_matcher.sv */
// Greedy delta-R matcher. Load requests fill a table of up to MAX_ENTRIES
// destination objects (eta, phi, pt); a new-event request empties it. Each
// match request scans the loaded entries that are still free, keeps those
// inside the squared distance cut (phi difference wrapped into [-pi, pi)),
// picks the one closest in pt (later entry on ties), marks it taken and
// returns its index, or -1 when none qualifies, with the query's ordinal in
// the event. Load and clear give no result, and ready stays high after them.
// A match holds ready low until its result posts, so no new request is taken
// during its scan: the entry memory delivers one entry per cycle into a
// three-stage distance pipeline, which drains before the result posts; an
// empty table skips the scan and goes straight to posting.
// The result sits in an output register, so new loads and clears are taken
// while it waits; a following match cannot post until it is taken. The
// taken marks live in memory and are rewritten as entries load, so reset and
// new-event requests need no clearing pass.
module greedy_delta_r_matcher #(
    parameter int MAX_ENTRIES = gdrm_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [gdrm_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [gdrm_pkg::ETA_W-1:0]   i_coord_eta,
    input  logic signed [gdrm_pkg::PHI_W-1:0]   i_coord_phi,
    input  logic [gdrm_pkg::PT_W-1:0]           i_momentum_pt,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [gdrm_pkg::MIDX_W-1:0]  o_match_index,
    output logic [gdrm_pkg::SEQ_W-1:0]          o_source_seq,
    input  logic                                i_cfg_we,
    input  logic [gdrm_pkg::CUT_W-1:0]          i_cfg_wdata
);

    import gdrm_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CUT_W-1:0]  r_cut;
    logic [CNT_W-1:0]  r_entry_count;
    logic [SEQ_W-1:0]  r_query_count;

    // Query held for the scan
    logic signed [ETA_W-1:0] r_q_eta;
    logic signed [PHI_W-1:0] r_q_phi;
    logic [PT_W-1:0]         r_q_pt;

    // Scan address and pipeline
    logic [IDX_W-1:0]        r_addr;
    logic                    r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]        r_idx1, r_idx2, r_idx3;
    logic signed [ETA_W:0]   r_de;
    logic signed [PHI_W-1:0] r_dp;
    logic [PT_W-1:0]         r_ptd2, r_ptd3;
    logic                    r_tk2, r_tk3;
    logic [CUT_W-1:0]        r_de2;
    logic [2*PHI_W-3:0]      r_dp2;

    // Running best
    logic                    r_found;
    logic [IDX_W-1:0]        r_best;
    logic [PT_W-1:0]         r_best_diff;

    // Output register
    logic                    r_out_valid;
    logic [MIDX_W-1:0]       r_out_index;
    logic [SEQ_W-1:0]        r_out_seq;

    logic                    w_accept;
    logic                    w_load_wr;
    logic                    w_room;
    logic                    w_last;
    logic                    w_post;

    logic [ENTRY_W-1:0]      w_ram_rdata;
    logic                    w_tk_rdata;
    logic                    w_tk_we;
    logic [IDX_W-1:0]        w_tk_waddr;
    logic                    w_tk_wdata;

    logic signed [ETA_W-1:0] w_e_eta;
    logic signed [PHI_W-1:0] w_e_phi;
    logic [PT_W-1:0]         w_e_pt;
    logic signed [PHI_W:0]   w_dp_raw;
    logic signed [PHI_W:0]   w_dp_wrap;
    logic [PT_W-1:0]         w_ptd;
    logic signed [2*ETA_W+1:0] w_de_sq;
    logic signed [2*PHI_W-1:0] w_dp_sq;
    logic [CUT_W:0]          w_dist;
    logic                    w_qual;
    logic                    w_take;
    logic [MIDX_W-1:0]       w_best7;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_room     = (r_entry_count < CNT_W'(MAX_ENTRIES));
    assign w_load_wr  = w_accept && (i_req_type == REQ_LOAD) && w_room;
    assign w_last     = ((CNT_W'(r_addr) + 1'b1) == r_entry_count);
    assign w_post     = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    // Entry memory: eta, phi, pt packed in one word
    gdrm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_wr),
        .i_waddr (r_entry_count[IDX_W-1:0]),
        .i_wdata ({i_coord_eta, i_coord_phi, i_momentum_pt}),
        .i_raddr (r_addr),
        .o_rdata (w_ram_rdata)
    );

    // Taken marks: cleared per entry on load, set on the winner
    assign w_tk_we    = w_load_wr || (w_post && r_found);
    assign w_tk_waddr = w_load_wr ? r_entry_count[IDX_W-1:0] : r_best;
    assign w_tk_wdata = !w_load_wr;

    gdrm_ram #(
        .WIDTH (1),
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_taken_ram (
        .i_clk   (i_clk),
        .i_we    (w_tk_we),
        .i_waddr (w_tk_waddr),
        .i_wdata (w_tk_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_tk_rdata)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req_type == REQ_MATCH)) begin
                    n_state = (r_entry_count == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_post) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Stage 2 inputs: differences and phi wrap
    assign w_e_eta  = w_ram_rdata[ENTRY_W-1 -: ETA_W];
    assign w_e_phi  = w_ram_rdata[PT_W +: PHI_W];
    assign w_e_pt   = w_ram_rdata[PT_W-1:0];
    assign w_dp_raw = (PHI_W+1)'(r_q_phi) - (PHI_W+1)'(w_e_phi);

    always_comb begin
        if (w_dp_raw >= PI_FIX) begin
            w_dp_wrap = w_dp_raw - TWO_PI_FIX;
        end else if (w_dp_raw < -PI_FIX) begin
            w_dp_wrap = w_dp_raw + TWO_PI_FIX;
        end else begin
            w_dp_wrap = w_dp_raw;
        end
    end

    assign w_ptd = (r_q_pt >= w_e_pt) ? (r_q_pt - w_e_pt) : (w_e_pt - r_q_pt);

    // Stage 3 inputs: squares
    assign w_de_sq = r_de * r_de;
    assign w_dp_sq = r_dp * r_dp;

    // Final stage: cut test and best selection
    assign w_dist = {1'b0, r_de2} + (CUT_W+1)'(r_dp2);
    assign w_qual = r_v3 && !r_tk3 && (w_dist <= {1'b0, r_cut});
    assign w_take = w_qual && (!r_found || (r_ptd3 <= r_best_diff));

    // Winner index to the 7-bit result field
    if (IDX_W >= MIDX_W) begin : g_idx_trunc
        assign w_best7 = r_best[MIDX_W-1:0];
    end else begin : g_idx_ext
        assign w_best7 = MIDX_W'(r_best);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cut         <= CUT_RESET;
            r_entry_count <= '0;
            r_query_count <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_SCAN);
            r_v2    <= r_v1;
            r_v3    <= r_v2;

            if (i_cfg_we) begin
                r_cut <= i_cfg_wdata;
            end

            if (w_accept && (i_req_type == REQ_CLEAR)) begin
                r_entry_count <= '0;
                r_query_count <= '0;
            end else if (w_load_wr) begin
                r_entry_count <= r_entry_count + 1'b1;
            end else if (w_post) begin
                r_query_count <= r_query_count + 1'b1;
            end

            if (w_accept && (i_req_type == REQ_MATCH)) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end

            if (w_post) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_req_type == REQ_MATCH)) begin
            r_q_eta <= i_coord_eta;
            r_q_phi <= i_coord_phi;
            r_q_pt  <= i_momentum_pt;
            r_addr  <= '0;
        end else if ((r_state == S_SCAN) && !w_last) begin
            r_addr  <= r_addr + 1'b1;
        end

        r_idx1 <= r_addr;

        r_idx2 <= r_idx1;
        r_de   <= (ETA_W+1)'(r_q_eta) - (ETA_W+1)'(w_e_eta);
        r_dp   <= w_dp_wrap[PHI_W-1:0];
        r_ptd2 <= w_ptd;
        r_tk2  <= w_tk_rdata;

        r_idx3 <= r_idx2;
        r_de2  <= w_de_sq[CUT_W-1:0];
        r_dp2  <= w_dp_sq[2*PHI_W-3:0];
        r_ptd3 <= r_ptd2;
        r_tk3  <= r_tk2;

        if (w_take) begin
            r_best      <= r_idx3;
            r_best_diff <= r_ptd3;
        end

        if (w_post) begin
            r_out_index <= r_found ? w_best7 : NO_MATCH;
            r_out_seq   <= r_query_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_index = r_out_index;
    assign o_source_seq  = r_out_seq;

endmodule

/* hw/rtl/gdrm_checker.sv */
module gdrm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [gdrm_pkg::REQ_W-1:0]          i_req_type,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [gdrm_pkg::MIDX_W-1:0]  o_match_index,
    input logic [gdrm_pkg::SEQ_W-1:0]          o_source_seq
);

    import gdrm_pkg::*;

    // Leaving reset: ready for input, no result pending
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("block not idle after reset");

    // A match transfer starts a scan and drops ready
    a_match_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_req_type == REQ_MATCH) |=> !o_in_ready)
        else $error("ready stayed high after a match transfer");

    // Loads, clears and unused codes leave ready high
    a_short_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_req_type != REQ_MATCH) |=> o_in_ready)
        else $error("ready dropped after a load or clear transfer");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_match_index) && $stable(o_source_seq)))
        else $error("result changed while stalled");

endmodule

bind greedy_delta_r_matcher gdrm_checker u_gdrm_checker (.*);
